[rtl/assert_macros.svh]
// Assertion macros used by the checker file of this block.
// Each macro expands to one labeled concurrent assertion with a reset guard.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define FMR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define FMR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/fmr_pkg.sv]
// Shared types and constants for the footprint min/max radius block.
// No dependencies.
package fmr_pkg;

    localparam int DIST_BITS = 16;

    typedef logic [DIST_BITS-1:0] dist_t;

    localparam dist_t DIST_MAX = '1;

endpackage

[rtl/footprint_min_max_radius_unit.sv]
// Inscribed and circumscribed radius of a polygon footprint about the origin. Vertices come in
// one per transfer, signed, in any fixed-point scale (the scale passes through unchanged); the
// last one is marked. A vertex that follows another runs the bit-serial multipliers, then the
// bit-serial squaring of the edge cross product, followed by the 16-step root; the marked vertex
// runs that twice to close the polygon. The result waits in an output register, so the next
// polygon may start while it is not yet taken. Polygons of two or fewer vertices give min all
// ones, max zero and the too_few_vertices flag.
module footprint_min_max_radius_unit #(
    parameter int COORD_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_BITS-1:0]  vertex_x,
    input  logic signed [COORD_BITS-1:0]  vertex_y,
    input  logic                          last_vertex,
    output logic                          out_valid,
    input  logic                          out_stall,
    output fmr_pkg::dist_t                min_distance,
    output fmr_pkg::dist_t                max_distance,
    output logic                          too_few_vertices
);
    import fmr_pkg::*;

    localparam int W1 = COORD_BITS + 1;
    localparam int PW = 2 * W1 + 1;
    localparam int SW = 2 * PW + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_SQ    = 3'd3;
    localparam logic [2:0] S_ROOT  = 3'd4;
    localparam logic [2:0] S_TAKE  = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [1:0] count_reg, count_next;
    dist_t      min_reg, min_next;
    dist_t      max_reg, max_next;
    logic       pass_reg, pass_next;
    logic       last_reg, last_next;
    logic       few_reg, few_next;
    logic       out_valid_reg, out_valid_next;

    logic signed [COORD_BITS-1:0] first_x_reg, first_y_reg;
    logic signed [COORD_BITS-1:0] prev_x_reg, prev_y_reg;
    logic signed [COORD_BITS-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    dist_t min_out_reg, max_out_reg;
    logic  few_out_reg;

    logic in_xfer, out_xfer, load_out;
    logic load_first_pair, load_close_pair;

    logic signed [W1-1:0] ax1, ay1, bx1, by1, dx, dy, nay;
    logic signed [PW-1:0] nv_acc, ad_acc, bd_acc, cr_acc, len_acc;
    logic signed [SW-1:0] sq_acc;
    logic nv_busy, ad_busy, bd_busy, cr_busy, len_busy, sq_busy, vroot_busy, eroot_busy;
    logic mul_busy, mul_start, sq_start, eroot_start, perp;
    dist_t vq, eq, min1, max1;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_xfer  = out_valid_reg && !out_stall;
    assign load_out  = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);

    assign out_valid        = out_valid_reg;
    assign min_distance     = min_out_reg;
    assign max_distance     = max_out_reg;
    assign too_few_vertices = few_out_reg;

    // Operands of the current edge, start a to end b
    assign ax1 = W1'(ax_reg);
    assign ay1 = W1'(ay_reg);
    assign bx1 = W1'(bx_reg);
    assign by1 = W1'(by_reg);
    assign dx  = bx1 - ax1;
    assign dy  = by1 - ay1;
    assign nay = -ay1;

    assign mul_busy    = nv_busy || ad_busy || bd_busy || cr_busy || len_busy;
    assign mul_start   = (state_reg == S_START);
    assign sq_start    = (state_reg == S_MUL) && !mul_busy;
    assign eroot_start = (state_reg == S_SQ) && !sq_busy && !vroot_busy;

    fmr_dot #(.AW(W1), .BW(W1)) u_nv (
        .clk(clk), .rst_n(rst_n), .start(mul_start),
        .a0(ax1), .b0(ax1), .a1(ay1), .b1(ay1), .acc(nv_acc), .busy(nv_busy)
    );

    fmr_dot #(.AW(W1), .BW(W1)) u_ad (
        .clk(clk), .rst_n(rst_n), .start(mul_start),
        .a0(ax1), .b0(dx), .a1(ay1), .b1(dy), .acc(ad_acc), .busy(ad_busy)
    );

    fmr_dot #(.AW(W1), .BW(W1)) u_bd (
        .clk(clk), .rst_n(rst_n), .start(mul_start),
        .a0(bx1), .b0(dx), .a1(by1), .b1(dy), .acc(bd_acc), .busy(bd_busy)
    );

    fmr_dot #(.AW(W1), .BW(W1)) u_cr (
        .clk(clk), .rst_n(rst_n), .start(mul_start),
        .a0(ax1), .b0(by1), .a1(nay), .b1(bx1), .acc(cr_acc), .busy(cr_busy)
    );

    fmr_dot #(.AW(W1), .BW(W1)) u_len (
        .clk(clk), .rst_n(rst_n), .start(mul_start),
        .a0(dx), .b0(dx), .a1(dy), .b1(dy), .acc(len_acc), .busy(len_busy)
    );

    fmr_dot #(.AW(PW), .BW(PW)) u_sq (
        .clk(clk), .rst_n(rst_n), .start(sq_start),
        .a0(cr_acc), .b0(cr_acc), .a1('0), .b1('0), .acc(sq_acc), .busy(sq_busy)
    );

    fmr_root #(.NW(PW), .LW(1)) u_vroot (
        .clk(clk), .rst_n(rst_n), .start(sq_start),
        .num($unsigned(nv_acc)), .len(1'b1), .q(vq), .busy(vroot_busy)
    );

    fmr_root #(.NW(SW), .LW(PW)) u_eroot (
        .clk(clk), .rst_n(rst_n), .start(eroot_start),
        .num($unsigned(sq_acc)), .len($unsigned(len_acc)), .q(eq), .busy(eroot_busy)
    );

    // Clamped edge cases repeat a vertex distance that is taken anyway; only the
    // perpendicular foot inside the edge adds a new distance.
    assign perp = ad_acc[PW-1] && !bd_acc[PW-1] && (bd_acc != '0);

    always_comb
    begin
        min1 = (vq < min_reg) ? vq : min_reg;
        max1 = (vq > max_reg) ? vq : max_reg;
        if (perp && (eq < min1))
        begin
            min1 = eq;
        end
        if (perp && (eq > max1))
        begin
            max1 = eq;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        pass_next       = pass_reg;
        last_next       = last_reg;
        few_next        = few_reg;
        out_valid_next  = out_valid_reg;
        load_first_pair = 1'b0;
        load_close_pair = 1'b0;

        if (out_xfer)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    last_next  = last_vertex;
                    count_next = (count_reg == 2'd3) ? count_reg : count_reg + 1'b1;
                    if (count_reg != 2'd0)
                    begin
                        load_first_pair = 1'b1;
                        pass_next       = 1'b0;
                        state_next      = S_START;
                    end
                    else if (last_vertex)
                    begin
                        few_next   = 1'b1;
                        state_next = S_EMIT;
                    end
                end
            end
            S_START:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (!mul_busy)
                begin
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                if (!sq_busy && !vroot_busy)
                begin
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                if (!eroot_busy)
                begin
                    state_next = S_TAKE;
                end
            end
            S_TAKE:
            begin
                min_next = min1;
                max_next = max1;
                if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (pass_reg)
                begin
                    few_next   = 1'b0;
                    state_next = S_EMIT;
                end
                else if (count_reg == 2'd3)
                begin
                    // close the polygon: last vertex back to the first
                    load_close_pair = 1'b1;
                    pass_next       = 1'b1;
                    state_next      = S_START;
                end
                else
                begin
                    few_next   = 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    count_next     = 2'd0;
                    min_next       = DIST_MAX;
                    max_next       = '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= 2'd0;
            min_reg       <= DIST_MAX;
            max_reg       <= '0;
            pass_reg      <= 1'b0;
            last_reg      <= 1'b0;
            few_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            pass_reg      <= pass_next;
            last_reg      <= last_next;
            few_reg       <= few_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            prev_x_reg <= vertex_x;
            prev_y_reg <= vertex_y;
            if (count_reg == 2'd0)
            begin
                first_x_reg <= vertex_x;
                first_y_reg <= vertex_y;
            end
        end
        if (load_first_pair)
        begin
            ax_reg <= prev_x_reg;
            ay_reg <= prev_y_reg;
            bx_reg <= vertex_x;
            by_reg <= vertex_y;
        end
        else if (load_close_pair)
        begin
            ax_reg <= bx_reg;
            ay_reg <= by_reg;
            bx_reg <= first_x_reg;
            by_reg <= first_y_reg;
        end
        if (load_out)
        begin
            min_out_reg <= few_reg ? DIST_MAX : min_reg;
            max_out_reg <= few_reg ? '0 : max_reg;
            few_out_reg <= few_reg;
        end
    end

endmodule

[rtl/fmr_dot.sv]
// Bit-serial signed dot product a0*b0 + a1*b1, multiplier bits MSB first.
// Depends on nothing else.
module fmr_dot #(
    parameter int AW = 17,
    parameter int BW = 17
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [AW-1:0]    a0,
    input  logic signed [BW-1:0]    b0,
    input  logic signed [AW-1:0]    a1,
    input  logic signed [BW-1:0]    b1,
    output logic signed [AW+BW:0]   acc,
    output logic                    busy
);
    localparam int ACCW = AW + BW + 1;
    localparam int CW   = $clog2(BW + 1);

    logic [CW-1:0]          cnt_reg;
    logic signed [AW-1:0]   a0_reg;
    logic signed [AW-1:0]   a1_reg;
    logic [BW-1:0]          b0_reg;
    logic [BW-1:0]          b1_reg;
    logic signed [ACCW-1:0] acc_reg;
    logic signed [ACCW-1:0] acc_next;
    logic signed [ACCW-1:0] t0;
    logic signed [ACCW-1:0] t1;

    assign busy = (cnt_reg != '0);
    assign acc  = acc_reg;

    always_comb
    begin
        t0 = b0_reg[BW-1] ? ACCW'(a0_reg) : '0;
        t1 = b1_reg[BW-1] ? ACCW'(a1_reg) : '0;
        // sign bit of the multiplier carries negative weight
        if (cnt_reg == CW'(BW))
        begin
            t0 = -t0;
            t1 = -t1;
        end
        acc_next = (acc_reg <<< 1) + t0 + t1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CW'(BW);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a0_reg  <= a0;
            a1_reg  <= a1;
            b0_reg  <= b0;
            b1_reg  <= b1;
            acc_reg <= '0;
        end
        else if (busy)
        begin
            b0_reg  <= b0_reg << 1;
            b1_reg  <= b1_reg << 1;
            acc_reg <= acc_next;
        end
    end

endmodule

[rtl/fmr_root.sv]
// Digit-serial root: largest q below 2**DIST_BITS with q*q*len <= num.
// One result bit per cycle, MSB first. Depends on fmr_pkg.
module fmr_root #(
    parameter int NW = 35,
    parameter int LW = 35
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [NW-1:0]   num,
    input  logic [LW-1:0]   len,
    output fmr_pkg::dist_t  q,
    output logic            busy
);
    import fmr_pkg::*;

    localparam int QW = DIST_BITS;
    localparam int RW = (NW > LW + 2 * QW + 1) ? NW : LW + 2 * QW + 1;
    localparam int CW = $clog2(QW + 1);

    logic [CW-1:0] cnt_reg;
    logic [RW-1:0] rem_reg;
    logic [RW-1:0] p_reg;     // q*len shifted up by (bit + 1)
    logic [RW-1:0] sl_reg;    // len shifted up by (2 * bit)
    dist_t         q_reg;
    logic [RW-1:0] delta;
    logic          take;

    assign busy  = (cnt_reg != '0);
    assign q     = q_reg;
    assign delta = p_reg + sl_reg;
    assign take  = (delta <= rem_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CW'(QW);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= RW'(num);
            p_reg   <= '0;
            sl_reg  <= RW'(len) << (2 * (QW - 1));
            q_reg   <= '0;
        end
        else if (busy)
        begin
            rem_reg <= take ? rem_reg - delta : rem_reg;
            p_reg   <= (take ? p_reg + (sl_reg << 1) : p_reg) >> 1;
            sl_reg  <= sl_reg >> 2;
            q_reg   <= {q_reg[QW-2:0], take};
        end
    end

endmodule

[rtl/fmr_checker.sv]
// Port-level checker for footprint_min_max_radius_unit, bound to the top level.
// Depends on fmr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fmr_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           out_valid,
    input logic           out_stall,
    input fmr_pkg::dist_t min_distance,
    input fmr_pkg::dist_t max_distance,
    input logic           too_few_vertices
);
    import fmr_pkg::*;

    // Degenerate polygon reports the fixed pair
    `FMR_ASSERT_IMPLY(a_few_values, clk, rst_n, out_valid && too_few_vertices, (min_distance == DIST_MAX) && (max_distance == '0))

    // A real polygon never reports min above max
    `FMR_ASSERT_IMPLY(a_min_le_max, clk, rst_n, out_valid && !too_few_vertices, min_distance <= max_distance)

    // Hold a stalled result
    `FMR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(min_distance) && $stable(max_distance))

endmodule

bind footprint_min_max_radius_unit fmr_checker u_fmr_checker (.*);
